[src/aip_pkg.sv]
`timescale 1ns / 1ps
// shared types and constants of the aitken interpolator
package aip_pkg;

  localparam int MAX_NODES = 16;
  localparam int FRAC_BITS = 16;  // q16.16 format; the update ratio has no unit

  localparam int DATA_W    = 32;
  localparam int MAG_W     = DATA_W + 1;
  localparam int HALF_W    = 17;
  localparam int PROD_W    = 2 * MAG_W;
  localparam int QUO_W     = 35;
  localparam int DIV_STEPS = QUO_W;
  localparam int DCNT_W    = $clog2(DIV_STEPS);

  localparam int IDX_W     = $clog2(MAX_NODES);
  localparam int CNT_W     = $clog2(MAX_NODES + 1);
  localparam int NC_W      = 5;
  localparam int SLOT_IN_W = 4;
  localparam int CMP_W     = (NC_W > CNT_W) ? NC_W : CNT_W;
  localparam int SLOT_W    = (SLOT_IN_W > IDX_W + 1) ? SLOT_IN_W : IDX_W + 1;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_DIVZERO = 2'd1;
  localparam logic [1:0] ST_SAT     = 2'd2;

  localparam logic OPC_LOAD = 1'b0;
  localparam logic OPC_EVAL = 1'b1;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_START,
    OP_COPY,
    OP_ROW,
    OP_UPD,
    OP_MUL,
    OP_DIVI,
    OP_DIV,
    OP_WB,
    OP_OUT
  } op_t;

  typedef struct packed {
    op_t             op;
    logic [IDX_W-1:0] addr;
    logic [1:0]       step;
  } cmd_t;

  typedef struct packed {
    logic e_zero;
  } stat_t;

endpackage

[src/aip_datapath.sv]
`timescale 1ns / 1ps
// datapath: node tables, scratch table, serial multiply and divide
module aip_datapath
  import aip_pkg::*;
(
  input  logic                     clk,
  input  cmd_t                     cmd,
  output stat_t                    stat,
  input  logic [SLOT_IN_W-1:0]     in_node_index,
  input  logic signed [DATA_W-1:0] in_node_x,
  input  logic signed [DATA_W-1:0] in_node_y,
  input  logic signed [DATA_W-1:0] in_query_x,
  output logic signed [DATA_W-1:0] out_value,
  output logic [1:0]               out_status
);

  logic [DATA_W-1:0] x_mem [MAX_NODES];
  logic [DATA_W-1:0] y_mem [MAX_NODES];
  logic [DATA_W-1:0] s_mem [MAX_NODES];
  logic [DATA_W-1:0] x_rd_r, y_rd_r, s_rd_r;

  logic [DATA_W-1:0] qx_r, a_r, xi_r;
  logic [MAG_W-1:0]  tmag_r, dmag_r, emag_r;
  logic              tneg_r, dneg_r, eneg_r;
  logic [PROD_W-1:0] prod_r;
  logic [MAG_W-1:0]  rem_r;
  logic [QUO_W-1:0]  qsh_r;
  logic              big_r, sat_acc_r, divz_r;
  logic [DATA_W-1:0] out_value_r;
  logic [1:0]        out_status_r;

  logic [SLOT_W-1:0] slot_ext;
  logic              slot_ok;
  logic [MAG_W-1:0]  t_full, d_full, e_full;
  logic [HALF_W-1:0] mul_a, mul_b;
  logic [2*HALF_W-1:0] mul_p;
  logic [PROD_W-1:0] mul_term;
  logic [MAG_W:0]    trial;
  logic              trial_ge;
  logic              neg, over, ovf;
  logic [QUO_W:0]    sum;
  logic [DATA_W-1:0] wb_res;

  localparam logic [DATA_W-1:0] S_MAX = {1'b0, {(DATA_W-1){1'b1}}};
  localparam logic [DATA_W-1:0] S_MIN = {1'b1, {(DATA_W-1){1'b0}}};
  localparam logic [QUO_W-1:0]  Q_LIM = QUO_W'(1) << (MAG_W);

  assign slot_ext = SLOT_W'(in_node_index);
  assign slot_ok  = slot_ext < SLOT_W'(MAX_NODES);

  assign t_full = {qx_r[DATA_W-1], qx_r} - {x_rd_r[DATA_W-1], x_rd_r};
  assign d_full = {a_r[DATA_W-1], a_r} - {s_rd_r[DATA_W-1], s_rd_r};
  assign e_full = {xi_r[DATA_W-1], xi_r} - {x_rd_r[DATA_W-1], x_rd_r};
  assign stat.e_zero = (x_rd_r == xi_r);

  // 17 x 17 partial products, one per cycle
  always_comb begin
    unique case (cmd.step)
      2'd0: begin
        mul_a = dmag_r[HALF_W-1:0];
        mul_b = tmag_r[HALF_W-1:0];
      end
      2'd1: begin
        mul_a = dmag_r[HALF_W-1:0];
        mul_b = HALF_W'(tmag_r[MAG_W-1:HALF_W]);
      end
      2'd2: begin
        mul_a = HALF_W'(dmag_r[MAG_W-1:HALF_W]);
        mul_b = tmag_r[HALF_W-1:0];
      end
      default: begin
        mul_a = HALF_W'(dmag_r[MAG_W-1:HALF_W]);
        mul_b = HALF_W'(tmag_r[MAG_W-1:HALF_W]);
      end
    endcase
    mul_p = mul_a * mul_b;
    unique case (cmd.step)
      2'd0:    mul_term = PROD_W'(mul_p);
      2'd1,
      2'd2:    mul_term = PROD_W'(mul_p) << HALF_W;
      default: mul_term = PROD_W'(mul_p) << (2 * HALF_W);
    endcase
  end

  // restoring division step
  assign trial    = {rem_r, qsh_r[QUO_W-1]};
  assign trial_ge = trial >= {1'b0, emag_r};

  // write-back with saturation
  always_comb begin
    neg  = dneg_r ^ tneg_r ^ eneg_r;
    over = big_r || (qsh_r > Q_LIM);
    sum  = {{(QUO_W + 1 - DATA_W){a_r[DATA_W-1]}}, a_r}
         + (neg ? -(QUO_W + 1)'(qsh_r) : (QUO_W + 1)'(qsh_r));
    ovf  = (sum[QUO_W:DATA_W-1] != '0) && (sum[QUO_W:DATA_W-1] != '1);
    if (over) begin
      wb_res = neg ? S_MIN : S_MAX;
    end else if (ovf) begin
      wb_res = sum[QUO_W] ? S_MIN : S_MAX;
    end else begin
      wb_res = sum[DATA_W-1:0];
    end
  end

  // tables
  always_ff @(posedge clk) begin
    if (cmd.op == OP_LOAD && slot_ok) begin
      x_mem[slot_ext[IDX_W-1:0]] <= in_node_x;
      y_mem[slot_ext[IDX_W-1:0]] <= in_node_y;
    end
    if (cmd.op == OP_COPY) begin
      s_mem[cmd.addr] <= y_rd_r;
    end else if (cmd.op == OP_WB) begin
      s_mem[cmd.addr] <= wb_res;
    end
    x_rd_r <= x_mem[cmd.addr];
    y_rd_r <= y_mem[cmd.addr];
    s_rd_r <= s_mem[cmd.addr];
  end

  // working registers
  always_ff @(posedge clk) begin
    unique case (cmd.op)
      OP_START: begin
        qx_r      <= in_query_x;
        sat_acc_r <= 1'b0;
        divz_r    <= 1'b0;
      end
      OP_ROW: begin
        a_r    <= s_rd_r;
        xi_r   <= x_rd_r;
        tneg_r <= t_full[MAG_W-1];
        tmag_r <= t_full[MAG_W-1] ? -t_full : t_full;
      end
      OP_UPD: begin
        dneg_r <= d_full[MAG_W-1];
        dmag_r <= d_full[MAG_W-1] ? -d_full : d_full;
        eneg_r <= e_full[MAG_W-1];
        emag_r <= e_full[MAG_W-1] ? -e_full : e_full;
        prod_r <= '0;
        if (stat.e_zero) divz_r <= 1'b1;
      end
      OP_MUL: prod_r <= prod_r + mul_term;
      OP_DIVI: begin
        big_r <= MAG_W'(prod_r[PROD_W-1:QUO_W]) >= emag_r;
        rem_r <= MAG_W'(prod_r[PROD_W-1:QUO_W]);
        qsh_r <= prod_r[QUO_W-1:0];
      end
      OP_DIV: begin
        rem_r <= trial_ge ? MAG_W'(trial - {1'b0, emag_r}) : trial[MAG_W-1:0];
        qsh_r <= {qsh_r[QUO_W-2:0], trial_ge};
      end
      OP_WB: begin
        a_r <= wb_res;
        if (over || ovf) sat_acc_r <= 1'b1;
      end
      OP_OUT: begin
        out_value_r  <= divz_r ? '0 : s_rd_r;
        out_status_r <= divz_r ? ST_DIVZERO : (sat_acc_r ? ST_SAT : ST_OK);
      end
      default: ;
    endcase
  end

  assign out_value  = out_value_r;
  assign out_status = out_status_r;

endmodule

[src/aip_ctrl.sv]
`timescale 1ns / 1ps
// controller: sequencing of copy, update rows, multiply and divide
module aip_ctrl
  import aip_pkg::*;
(
  input  logic            clk,
  input  logic            rst_n,
  input  logic            cfg_wr_en,
  input  logic [NC_W-1:0] cfg_wr_data,
  input  logic            in_valid,
  output logic            in_stall,
  input  logic            in_opcode,
  output logic            out_valid,
  input  logic            out_stall,
  output cmd_t            cmd,
  input  stat_t           stat
);

  typedef enum logic [3:0] {
    S_IDLE, S_COPY_RD, S_COPY_WR, S_ROW_RD, S_ROW_LD, S_UPD_RD, S_UPD_LD,
    S_MUL, S_DIVI, S_DIV, S_WB, S_FIN_RD, S_DONE
  } state_t;

  state_t            state_r;
  logic [NC_W-1:0]   node_count_r;
  logic [CNT_W-1:0]  n_r;
  logic [IDX_W-1:0]  j_r, i_r, k_r;
  logic [1:0]        step_r;
  logic [DCNT_W-1:0] dcnt_r;
  logic              out_valid_r;

  logic              in_acc, out_free;
  logic [CMP_W-1:0]  nc_ext;
  logic [CNT_W-1:0]  n_clamp;
  logic [IDX_W-1:0]  last_idx;

  assign in_stall = (state_r != S_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;
  assign out_valid = out_valid_r;
  assign last_idx = IDX_W'(n_r - CNT_W'(1));

  always_comb begin
    nc_ext = CMP_W'(node_count_r);
    priority if (nc_ext == '0) begin
      n_clamp = CNT_W'(1);
    end else if (nc_ext > CMP_W'(MAX_NODES)) begin
      n_clamp = CNT_W'(MAX_NODES);
    end else begin
      n_clamp = CNT_W'(nc_ext);
    end
  end

  always_comb begin
    cmd.op   = OP_NONE;
    cmd.addr = '0;
    cmd.step = step_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_acc) cmd.op = (in_opcode == OPC_EVAL) ? OP_START : OP_LOAD;
      end
      S_COPY_RD: cmd.addr = j_r;
      S_COPY_WR: begin
        cmd.addr = j_r;
        cmd.op   = OP_COPY;
      end
      S_ROW_RD:  cmd.addr = i_r;
      S_ROW_LD:  cmd.op = OP_ROW;
      S_UPD_RD:  cmd.addr = k_r;
      S_UPD_LD:  cmd.op = OP_UPD;
      S_MUL:     cmd.op = OP_MUL;
      S_DIVI:    cmd.op = OP_DIVI;
      S_DIV:     cmd.op = OP_DIV;
      S_WB: begin
        cmd.addr = k_r;
        cmd.op   = OP_WB;
      end
      S_FIN_RD:  cmd.addr = '0;
      S_DONE:    if (out_free) cmd.op = OP_OUT;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      node_count_r <= NC_W'(1);
      out_valid_r  <= 1'b0;
      n_r          <= CNT_W'(1);
      j_r          <= '0;
      i_r          <= '0;
      k_r          <= '0;
      step_r       <= '0;
      dcnt_r       <= '0;
    end else begin
      if (cfg_wr_en) node_count_r <= cfg_wr_data;
      if (out_valid_r && !out_stall && state_r != S_DONE) out_valid_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (in_acc && in_opcode == OPC_EVAL) begin
            n_r     <= n_clamp;
            j_r     <= '0;
            state_r <= S_COPY_RD;
          end
        end
        S_COPY_RD: state_r <= S_COPY_WR;
        S_COPY_WR: begin
          if (j_r == last_idx) begin
            i_r     <= IDX_W'(1);
            state_r <= (n_r == CNT_W'(1)) ? S_FIN_RD : S_ROW_RD;
          end else begin
            j_r     <= j_r + IDX_W'(1);
            state_r <= S_COPY_RD;
          end
        end
        S_ROW_RD: state_r <= S_ROW_LD;
        S_ROW_LD: begin
          k_r     <= i_r - IDX_W'(1);
          state_r <= S_UPD_RD;
        end
        S_UPD_RD: state_r <= S_UPD_LD;
        S_UPD_LD: begin
          step_r  <= '0;
          state_r <= stat.e_zero ? S_DONE : S_MUL;
        end
        S_MUL: begin
          step_r <= step_r + 2'd1;
          if (step_r == 2'd3) state_r <= S_DIVI;
        end
        S_DIVI: begin
          dcnt_r  <= '0;
          state_r <= S_DIV;
        end
        S_DIV: begin
          dcnt_r <= dcnt_r + DCNT_W'(1);
          if (dcnt_r == DCNT_W'(DIV_STEPS - 1)) state_r <= S_WB;
        end
        S_WB: begin
          if (k_r != '0) begin
            k_r     <= k_r - IDX_W'(1);
            state_r <= S_UPD_RD;
          end else if (i_r == last_idx) begin
            state_r <= S_FIN_RD;
          end else begin
            i_r     <= i_r + IDX_W'(1);
            state_r <= S_ROW_RD;
          end
        end
        S_FIN_RD: state_r <= S_DONE;
        S_DONE: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

[src/aitken_polynomial_interpolator.sv]
`timescale 1ns / 1ps
// top level of the aitken-neville polynomial interpolator
// usage:
//   input channel (in_valid / in_stall) carries one transaction per operation:
//   in_opcode load writes node in_node_x / in_node_y into slot in_node_index and
//   gives no result; evaluate interpolates at in_query_x over the first
//   node_count nodes (written beforehand through cfg_wr_en / cfg_wr_data)
//   result channel (out_valid / out_stall) gives out_value in q16.16 and
//   out_status: ok, equal abscissas (value 0) or saturated
//   load does not occupy the block; in_stall stays low after it
//   evaluate with n nodes runs up to n(n-1)/2 updates after copying the n ordinates;
//   each update uses the four-step partial product multiplier and the
//   35-step restoring divider
//   one evaluation is in flight at a time; in_stall is high while it runs
//   the result waits in an output register; a stalled receiver holds the next
//   evaluation at its final step, and in_stall stays high until it moves on
//   synchronous reset clears control state and sets node_count to 1; node
//   tables are undefined until loaded
module aitken_polynomial_interpolator
  import aip_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     cfg_wr_en,
  input  logic [NC_W-1:0]          cfg_wr_data,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic                     in_opcode,
  input  logic [SLOT_IN_W-1:0]     in_node_index,
  input  logic signed [DATA_W-1:0] in_node_x,
  input  logic signed [DATA_W-1:0] in_node_y,
  input  logic signed [DATA_W-1:0] in_query_x,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic signed [DATA_W-1:0] out_value,
  output logic [1:0]               out_status
);

  // command and status between sequencer and arithmetic
  cmd_t  cmd;
  stat_t stat;

  aip_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_opcode   (in_opcode),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .cmd         (cmd),
    .stat        (stat)
  );

  aip_datapath u_dp (
    .clk           (clk),
    .cmd           (cmd),
    .stat          (stat),
    .in_node_index (in_node_index),
    .in_node_x     (in_node_x),
    .in_node_y     (in_node_y),
    .in_query_x    (in_query_x),
    .out_value     (out_value),
    .out_status    (out_status)
  );

endmodule

[src/aip_checker.sv]
`timescale 1ns / 1ps
// port-level checks of the interpolator, bound to the top level
module aip_checker
  import aip_pkg::*;
(
  input logic                     clk,
  input logic                     rst_n,
  input logic                     cfg_wr_en,
  input logic [NC_W-1:0]          cfg_wr_data,
  input logic                     in_valid,
  input logic                     in_stall,
  input logic                     in_opcode,
  input logic [SLOT_IN_W-1:0]     in_node_index,
  input logic signed [DATA_W-1:0] in_node_x,
  input logic signed [DATA_W-1:0] in_node_y,
  input logic signed [DATA_W-1:0] in_query_x,
  input logic                     out_valid,
  input logic                     out_stall,
  input logic signed [DATA_W-1:0] out_value,
  input logic [1:0]               out_status
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_value) && $stable(out_status))
    else $error("stalled result changed");

  a_eval_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_opcode == OPC_EVAL |=> in_stall)
    else $error("evaluate did not occupy the block");

  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_opcode == OPC_LOAD |=> !in_stall)
    else $error("load did not complete in one cycle");

  a_divz_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == ST_DIVZERO |-> out_value == '0)
    else $error("divide-by-zero result carries a value");

endmodule

bind aitken_polynomial_interpolator aip_checker u_aip_checker (.*);

[tb/sv/tb_aitken_polynomial_interpolator.sv]
`timescale 1ns / 1ps
// self-checking testbench of the aitken-neville polynomial interpolator
module tb_aitken_polynomial_interpolator;
  import aip_pkg::*;

  localparam int CLK_HALF   = 6;
  localparam int CYCLE_CAP  = 5000000;
  localparam int SETTLE     = 200;
  localparam int HOLD_LEN   = 4000;

  typedef struct {
    logic                     opc;
    logic [SLOT_IN_W-1:0]     idx;
    logic signed [DATA_W-1:0] nx;
    logic signed [DATA_W-1:0] ny;
    logic signed [DATA_W-1:0] qx;
  } node_txn_t;

  typedef struct {
    logic signed [DATA_W-1:0] value;
    logic [1:0]               status;
  } interp_res_t;

  logic                     clk = 1'b0;
  logic                     rst_n = 1'b0;
  logic                     cfg_wr_en = 1'b0;
  logic [NC_W-1:0]          cfg_wr_data = '0;
  logic                     in_valid = 1'b0;
  logic                     in_stall;
  logic                     in_opcode = OPC_LOAD;
  logic [SLOT_IN_W-1:0]     in_node_index = '0;
  logic signed [DATA_W-1:0] in_node_x = '0;
  logic signed [DATA_W-1:0] in_node_y = '0;
  logic signed [DATA_W-1:0] in_query_x = '0;
  logic                     out_valid;
  logic                     out_stall = 1'b0;
  logic signed [DATA_W-1:0] out_value;
  logic [1:0]               out_status;

  aitken_polynomial_interpolator uut (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_opcode     (in_opcode),
    .in_node_index (in_node_index),
    .in_node_x     (in_node_x),
    .in_node_y     (in_node_y),
    .in_query_x    (in_query_x),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_value     (out_value),
    .out_status    (out_status)
  );

  always #CLK_HALF clk = ~clk;

  // predictor state: node tables as the block should hold them, and node_count
  logic signed [DATA_W-1:0] abs_tab [MAX_NODES];
  logic signed [DATA_W-1:0] ord_tab [MAX_NODES];
  logic [NC_W-1:0]          count_reg = 5'd1;

  // abscissas as the generator has queued them, used to build duplicates
  logic signed [DATA_W-1:0] gen_abs [MAX_NODES];

  node_txn_t   pending_txns[$];
  interp_res_t expected_results[$];
  node_txn_t   cur_txn;

  int  fail_count = 0;
  int  cycle_count = 0;
  bit  quiet = 1'b0;       // no idling on either side in the closing part
  bit  hold_arm = 1'b0;
  bit  hold_seen = 1'b0;
  int  hold_left = 0;
  int  send_gap = 0;
  int  recv_gap = 0;

  task automatic report_mismatch(input string what);
    $display("mismatch at %0t: %s", $time, what);
    fail_count++;
  endtask

  // one neville update with saturation, magnitude division toward zero
  function automatic logic signed [DATA_W-1:0] neville_step(
      input longint a, input longint b, input longint t, input longint e,
      inout bit sat);
    longint      d, s;
    logic [127:0] md, mt, me, q;
    bit          neg;
    d   = a - b;
    md  = (d < 0) ? -d : d;
    mt  = (t < 0) ? -t : t;
    me  = (e < 0) ? -e : e;
    q   = (md * mt) / me;
    neg = ((d < 0) != (t < 0)) != (e < 0);
    if (q > (128'd1 << 33)) begin
      sat = 1'b1;
      return neg ? 32'sh80000000 : 32'sh7fffffff;
    end
    s = neg ? a - longint'(q[63:0]) : a + longint'(q[63:0]);
    if (s > 64'sd2147483647) begin
      sat = 1'b1;
      s   = 64'sd2147483647;
    end else if (s < -64'sd2147483648) begin
      sat = 1'b1;
      s   = -64'sd2147483648;
    end
    return s[31:0];
  endfunction

  // interpolated value at qx over the first node_count nodes
  function automatic interp_res_t interpolate(input logic signed [DATA_W-1:0] qx);
    interp_res_t              r;
    logic signed [DATA_W-1:0] p [MAX_NODES];
    int                       n;
    longint                   xi, t, e;
    bit                       sat;
    sat = 1'b0;
    n   = (count_reg == 0) ? 1 : (count_reg > MAX_NODES) ? MAX_NODES : count_reg;
    for (int j = 0; j < n; j++) p[j] = ord_tab[j];
    for (int i = 1; i < n; i++) begin
      xi = abs_tab[i];
      t  = longint'(qx) - xi;
      for (int k = i - 1; k >= 0; k--) begin
        e = xi - longint'(abs_tab[k]);
        if (e == 0) begin
          r.value  = '0;
          r.status = ST_DIVZERO;
          return r;
        end
        p[k] = neville_step(p[k+1], p[k], t, e, sat);
      end
    end
    r.value  = p[0];
    r.status = sat ? ST_SAT : ST_OK;
    return r;
  endfunction

  // accepted transaction: loads update the tables, evaluations expect a result
  function automatic void absorb_txn(input node_txn_t tx);
    if (tx.opc == OPC_LOAD) begin
      abs_tab[tx.idx] = tx.nx;
      ord_tab[tx.idx] = tx.ny;
    end else begin
      expected_results.push_back(interpolate(tx.qx));
    end
  endfunction

  // sender: one nonblocking update of valid per edge, payload held while stalled
  always @(posedge clk) begin : sender
    bit nv;
    if (!rst_n) begin
      in_valid <= 1'b0;
      send_gap <= 0;
    end else begin
      nv = in_valid;
      if (in_valid && !in_stall) begin
        absorb_txn(cur_txn);
        nv = 1'b0;
      end
      if (!nv) begin
        if (send_gap > 0) begin
          send_gap <= send_gap - 1;
        end else if (pending_txns.size() > 0) begin
          if (!quiet && $urandom_range(0, 4) == 0) begin
            send_gap <= $urandom_range(1, 9);
          end else begin
            cur_txn       = pending_txns.pop_front();
            nv            = 1'b1;
            in_opcode     <= cur_txn.opc;
            in_node_index <= cur_txn.idx;
            in_node_x     <= cur_txn.nx;
            in_node_y     <= cur_txn.ny;
            in_query_x    <= cur_txn.qx;
          end
        end
      end
      in_valid <= nv;
    end
  end

  // long receiver hold-off, counted here so the block fills up behind it
  always @(posedge clk) begin
    if (hold_arm && !hold_seen) begin
      hold_left <= HOLD_LEN;
      hold_seen <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // receiver: random stall bursts and the result check
  always @(posedge clk) begin : receiver
    interp_res_t exp_r;
    bit          ns;
    if (!rst_n) begin
      out_stall <= 1'b0;
      recv_gap  <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          report_mismatch($sformatf("unexpected result value %h status %0d",
                                    out_value, out_status));
        end else begin
          exp_r = expected_results.pop_front();
          if (out_value !== exp_r.value)
            report_mismatch($sformatf("value %h, expected %h", out_value, exp_r.value));
          if (out_status !== exp_r.status)
            report_mismatch($sformatf("status %0d, expected %0d",
                                      out_status, exp_r.status));
        end
      end
      ns = 1'b0;
      if (recv_gap > 0) begin
        recv_gap <= recv_gap - 1;
        ns = 1'b1;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        recv_gap <= $urandom_range(0, 8);
        ns = 1'b1;
      end
      out_stall <= ns || (hold_left > 0);
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_CAP) begin
      $display("aitken_polynomial_interpolator regression: fail");
      $finish;
    end
  end

  task automatic queue_load(input int idx, input logic signed [DATA_W-1:0] nx,
                            input logic signed [DATA_W-1:0] ny);
    node_txn_t tx;
    tx.opc = OPC_LOAD;
    tx.idx = SLOT_IN_W'(idx);
    tx.nx  = nx;
    tx.ny  = ny;
    tx.qx  = $urandom;
    gen_abs[idx] = nx;
    pending_txns.push_back(tx);
  endtask

  task automatic queue_eval(input logic signed [DATA_W-1:0] qx);
    node_txn_t tx;
    tx.opc = OPC_EVAL;
    tx.idx = SLOT_IN_W'($urandom);
    tx.nx  = $urandom;
    tx.ny  = $urandom;
    tx.qx  = qx;
    pending_txns.push_back(tx);
  endtask

  // block idle: everything sent, every result in, then margin for a late load
  task automatic drain();
    wait (pending_txns.size() == 0 && !in_valid && expected_results.size() == 0);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_count(input logic [NC_W-1:0] v);
    @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    count_reg   = v;
  endtask

  // random phase: mostly well-formed node sets followed by evaluations
  task automatic random_phase(input logic [NC_W-1:0] cnt, input int budget);
    int                       n, sent, sel, spacing, nev, a, b;
    logic signed [DATA_W-1:0] base;
    write_count(cnt);
    n    = (cnt == 0) ? 1 : (cnt > MAX_NODES) ? MAX_NODES : cnt;
    sent = 0;
    while (sent < budget) begin
      sel = $urandom_range(0, 9);
      if (sel < 6) begin
        spacing = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 1 << 26)
                                               : $urandom_range(1, 1 << 20);
        base    = $signed($urandom_range(0, 1 << 25)) - (1 << 24);
        for (int j = 0; j < n; j++) begin
          queue_load(j, base + j * spacing,
                     ($urandom_range(0, 7) == 0) ? $urandom
                                                 : $signed($urandom_range(0, 1 << 21)) - (1 << 20));
        end
        sent += n;
        nev = $urandom_range(1, 3);
        for (int j = 0; j < nev; j++)
          queue_eval(($urandom_range(0, 7) == 0) ? $urandom
                                                 : base + $urandom_range(0, n * spacing));
        sent += nev;
      end else if (sel < 8) begin
        queue_load($urandom_range(0, MAX_NODES - 1), $urandom, $urandom);
        sent++;
      end else if (sel == 8 && n > 1) begin
        // duplicate abscissa inside the used set, then evaluate
        a = $urandom_range(0, n - 1);
        b = (a + $urandom_range(1, n - 1)) % n;
        queue_load(b, gen_abs[a], $urandom);
        queue_eval($urandom);
        sent += 2;
      end else begin
        queue_eval($urandom);
        sent++;
      end
    end
    drain();
  endtask

  initial begin
    for (int j = 0; j < MAX_NODES; j++) begin
      abs_tab[j] = '0;
      ord_tab[j] = '0;
      gen_abs[j] = '0;
    end
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: every slot written, field extremes in slots 0 and 1
    queue_load(0, 32'sh80000000, 32'sh7fffffff);
    queue_load(1, 32'sh7fffffff, 32'sh80000000);
    for (int j = 2; j < MAX_NODES; j++) queue_load(j, j << 16, (j * j) << 16);
    queue_eval(32'sh00000000);          // single node after reset gives y[0]
    drain();
    write_count(5'd2);
    queue_eval(32'sh80000000);          // queries at the two extreme node abscissas
    queue_eval(32'sh7fffffff);
    drain();
    write_count(5'd3);
    queue_eval(32'sh00010000);
    queue_load(2, 32'sh7fffffff, 32'sh00000000);  // equal abscissas
    queue_eval(32'sh00000000);
    queue_load(2, 32'sh00020000, 32'sh00040000);
    drain();
    write_count(5'd0);                  // zero count behaves as one node
    queue_eval(32'sh12345678);
    drain();
    write_count(5'd31);                 // oversized count clamps to all nodes
    queue_eval(32'sh00018000);
    drain();

    random_phase(5'd4, 8);
    random_phase(5'd2, 8);
    random_phase(5'd0, 5);
    random_phase(5'd5, 8);
    hold_arm = 1'b1;                    // receiver holds off while loads and evals queue
    random_phase(5'd3, 8);
    random_phase(5'd17, 2);
    random_phase(5'd8, 6);
    random_phase(5'd16, 2);
    random_phase(5'd1, 5);
    quiet = 1'b1;
    random_phase(5'd6, 6);
    random_phase(5'd31, 2);

    wait (pending_txns.size() == 0 && !in_valid && expected_results.size() == 0);
    repeat (SETTLE) @(posedge clk);
    if (fail_count == 0 && expected_results.size() == 0) begin
      $display("aitken_polynomial_interpolator regression: pass");
    end else begin
      $display("aitken_polynomial_interpolator regression: fail");
    end
    $finish;
  end

endmodule

[filelist.f]
src/aip_pkg.sv
src/aip_datapath.sv
src/aip_ctrl.sv
src/aitken_polynomial_interpolator.sv
src/aip_checker.sv
tb/sv/tb_aitken_polynomial_interpolator.sv
